>>> sv/ise_pkg.sv
package ise_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int SLOT_W   = 4;
  localparam int VAL_W    = 32;

  localparam logic [1:0] OP_SEARCH = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_DELETE = 2'd2;
  localparam logic [1:0] OP_CLEAR  = 2'd3;

  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_PRESENT = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_MISSING = 2'd3;

  typedef logic [IDX_W-1:0] idx_t;

  typedef struct packed {
    logic [1:0]              opcode;
    logic signed [VAL_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic              ok;
    logic [1:0]        status;
    logic [SLOT_W-1:0] slot;
  } rsp_t;

  typedef struct packed {
    logic             we;
    idx_t             waddr;
    logic [VAL_W-1:0] wdata;
    idx_t             raddr;
  } mem_req_t;

endpackage

>>> sv/ise_mem.sv
module ise_mem
  import ise_pkg::*;
(
  input  logic             clk,
  input  mem_req_t         req,
  output logic [VAL_W-1:0] rd_data
);

  logic [VAL_W-1:0] mem [CAPACITY];
  logic [VAL_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rd_data_r <= mem[req.raddr];
  end

  assign rd_data = rd_data_r;

endmodule

>>> sv/ise_ctrl.sv
module ise_ctrl
  import ise_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  req_t             in_req,
  output logic             busy,
  output logic             out_valid,
  output rsp_t             out_rsp,
  output mem_req_t         mem_req,
  input  logic [VAL_W-1:0] rd_data
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_LAST = 2'd2;

  logic [1:0]          state_r, state_nxt;
  logic [1:0]          op_r, op_nxt;
  logic [VAL_W-1:0]    val_r, val_nxt;
  idx_t                cnt_r, cnt_nxt;
  logic                cmp_v_r, cmp_v_nxt;
  idx_t                cmp_idx_r, cmp_idx_nxt;
  logic                hit_r, hit_nxt;
  idx_t                hit_idx_r, hit_idx_nxt;
  logic                free_r, free_nxt;
  idx_t                free_idx_r, free_idx_nxt;
  logic [CAPACITY-1:0] valid_r, valid_nxt;
  logic                out_valid_r, out_valid_nxt;
  rsp_t                out_rsp_r, out_rsp_nxt;
  logic                match;

  assign match = cmp_v_r && !hit_r && valid_r[cmp_idx_r] && (rd_data == val_r);

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    val_nxt       = val_r;
    cnt_nxt       = cnt_r;
    cmp_v_nxt     = 1'b0;
    cmp_idx_nxt   = cnt_r;
    hit_nxt       = hit_r;
    hit_idx_nxt   = hit_idx_r;
    free_nxt      = free_r;
    free_idx_nxt  = free_idx_r;
    valid_nxt     = valid_r;
    out_valid_nxt = 1'b0;
    out_rsp_nxt   = out_rsp_r;
    mem_req.we    = 1'b0;
    mem_req.waddr = free_idx_r;
    mem_req.wdata = val_r;
    mem_req.raddr = cnt_r;

    if (match) begin
      hit_nxt     = 1'b1;
      hit_idx_nxt = cmp_idx_r;
    end

    case (state_r)
      S_IDLE: begin
        if (start) begin
          op_nxt    = in_req.opcode;
          val_nxt   = in_req.value;
          cnt_nxt   = '0;
          hit_nxt   = 1'b0;
          free_nxt  = 1'b0;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        cmp_v_nxt = 1'b1;
        if (!free_r && !valid_r[cnt_r]) begin
          free_nxt     = 1'b1;
          free_idx_nxt = cnt_r;
        end
        if (cnt_r == IDX_W'(CAPACITY - 1)) begin
          state_nxt = S_LAST;
        end else begin
          cnt_nxt = cnt_r + IDX_W'(1);
        end
      end
      S_LAST: begin
        state_nxt     = S_IDLE;
        out_valid_nxt = 1'b1;
        out_rsp_nxt   = '{ok: 1'b0, status: ST_MISSING, slot: '0};
        case (op_r)
          OP_SEARCH: begin
            if (hit_nxt) begin
              out_rsp_nxt = '{ok: 1'b1, status: ST_DONE, slot: SLOT_W'(hit_idx_nxt)};
            end
          end
          OP_INSERT: begin
            if (hit_nxt) begin
              out_rsp_nxt = '{ok: 1'b0, status: ST_PRESENT, slot: SLOT_W'(hit_idx_nxt)};
            end else if (free_r) begin
              mem_req.we             = 1'b1;
              valid_nxt[free_idx_r]  = 1'b1;
              out_rsp_nxt = '{ok: 1'b1, status: ST_DONE, slot: SLOT_W'(free_idx_r)};
            end else begin
              out_rsp_nxt = '{ok: 1'b0, status: ST_FULL, slot: '0};
            end
          end
          OP_DELETE: begin
            if (hit_nxt) begin
              valid_nxt[hit_idx_nxt] = 1'b0;
              out_rsp_nxt = '{ok: 1'b1, status: ST_DONE, slot: SLOT_W'(hit_idx_nxt)};
            end
          end
          default: begin
            valid_nxt   = '0;
            out_rsp_nxt = '{ok: 1'b1, status: ST_DONE, slot: '0};
          end
        endcase
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cmp_v_r     <= 1'b0;
      hit_r       <= 1'b0;
      free_r      <= 1'b0;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cmp_v_r     <= cmp_v_nxt;
      hit_r       <= hit_nxt;
      free_r      <= free_nxt;
      valid_r     <= valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
    op_r       <= op_nxt;
    val_r      <= val_nxt;
    cnt_r      <= cnt_nxt;
    cmp_idx_r  <= cmp_idx_nxt;
    hit_idx_r  <= hit_idx_nxt;
    free_idx_r <= free_idx_nxt;
    out_rsp_r  <= out_rsp_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

endmodule

>>> sv/integer_set_engine_core.sv
// Set of distinct 32-bit values in CAPACITY slots. Each item (search, insert,
// delete or clear) scans the value memory one slot per cycle. The out_valid
// pulse is registered as the controller leaves its final state S_LAST, after the
// scan state S_SCAN. A new item may start in the cycle that pulse appears, but the
// core takes no new item while it is still busy with the last one. The
// slot-by-slot scan through the value memory sets how often items can follow.
// busy is high from the cycle after start until the result is shown. The result
// stands for exactly one cycle and cannot be held off; capture it then.
module integer_set_engine_core
  import ise_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  input  req_t in_req,
  output logic busy,
  output logic out_valid,
  output rsp_t out_rsp
);

  mem_req_t         mem_req;
  logic [VAL_W-1:0] rd_data;

  ise_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_req    (in_req),
    .busy      (busy),
    .out_valid (out_valid),
    .out_rsp   (out_rsp),
    .mem_req   (mem_req),
    .rd_data   (rd_data)
  );

  ise_mem u_mem (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (rd_data)
  );

endmodule

>>> sv/ise_chk.sv
module ise_chk
  import ise_pkg::*;
(
  input logic clk,
  input logic rst_n,
  input logic start,
  input req_t in_req,
  input logic busy,
  input logic out_valid,
  input rsp_t out_rsp
);

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted item did not raise busy");

  a_single_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  a_done_frees: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid)
    else $error("busy dropped without a result");

  a_ok_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_rsp.ok == (out_rsp.status == ST_DONE)))
    else $error("ok and status disagree");

  a_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_rsp.status == ST_FULL || out_rsp.status == ST_MISSING))
      |-> (out_rsp.slot == '0))
    else $error("slot not zero on failure");

endmodule

bind integer_set_engine_core ise_chk u_chk (.*);

>>> bench/integer_set_checker.sv
module integer_set_checker
  import ise_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  input  logic busy,
  input  req_t in_req,
  input  logic out_valid,
  input  rsp_t out_rsp,
  output int   fail_count,
  output int   pending
);

  logic [VAL_W-1:0] set_vals [CAPACITY];
  bit               set_used [CAPACITY];
  rsp_t             expected_rsp [$];
  int               result_no;

  initial begin
    fail_count = 0;
    pending    = 0;
    result_no  = 0;
    foreach (set_used[i]) set_used[i] = 1'b0;
  end

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    $display("result %0d: %s expected %0h got %0h", result_no, what, want, got);
    fail_count++;
  endtask

  // Applies one item to the shadow set and returns the response it should give.
  function automatic rsp_t apply_set_op(input req_t r);
    rsp_t res;
    int   hit;
    int   spot;
    res  = '0;
    hit  = -1;
    spot = -1;
    for (int i = 0; i < CAPACITY; i++) begin
      if (hit < 0 && set_used[i] && set_vals[i] == r.value) hit = i;
      if (spot < 0 && !set_used[i]) spot = i;
    end
    case (r.opcode)
      OP_SEARCH: begin
        if (hit >= 0) begin
          res.ok   = 1'b1;
          res.status = ST_DONE;
          res.slot = hit[SLOT_W-1:0];
        end else begin
          res.status = ST_MISSING;
        end
      end
      OP_INSERT: begin
        if (hit >= 0) begin
          res.status = ST_PRESENT;
          res.slot = hit[SLOT_W-1:0];
        end else if (spot < 0) begin
          res.status = ST_FULL;
        end else begin
          set_vals[spot] = r.value;
          set_used[spot] = 1'b1;
          res.ok     = 1'b1;
          res.status = ST_DONE;
          res.slot   = spot[SLOT_W-1:0];
        end
      end
      OP_DELETE: begin
        if (hit >= 0) begin
          set_used[hit] = 1'b0;
          res.ok     = 1'b1;
          res.status = ST_DONE;
          res.slot   = hit[SLOT_W-1:0];
        end else begin
          res.status = ST_MISSING;
        end
      end
      default: begin
        foreach (set_used[i]) set_used[i] = 1'b0;
        res.ok     = 1'b1;
        res.status = ST_DONE;
      end
    endcase
    return res;
  endfunction

  always @(posedge clk) begin
    rsp_t want;
    if (!rst_n) begin
      foreach (set_used[i]) set_used[i] = 1'b0;
      expected_rsp.delete();
    end else begin
      // older item's result first; a new item may be accepted on the same edge
      if (out_valid === 1'b1) begin
        if (expected_rsp.size() == 0) begin
          report_mismatch("result with nothing due", '0, 32'(out_rsp));
        end else begin
          want = expected_rsp.pop_front();
          if (out_rsp.ok !== want.ok)
            report_mismatch("ok", 32'(want.ok), 32'(out_rsp.ok));
          if (out_rsp.status !== want.status)
            report_mismatch("status", 32'(want.status), 32'(out_rsp.status));
          if (out_rsp.slot !== want.slot)
            report_mismatch("slot", 32'(want.slot), 32'(out_rsp.slot));
        end
        result_no++;
      end
      if (start === 1'b1 && busy === 1'b0)
        expected_rsp.push_back(apply_set_op(in_req));
    end
    pending = expected_rsp.size();
  end

endmodule

>>> bench/tb_top.sv
module tb_top;
  import ise_pkg::*;

  localparam int POOL_N = 24;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  logic out_valid;
  req_t in_req;
  rsp_t out_rsp;
  int   fail_count;
  int   pending;

  int               gap_max;
  int               ins_pct;
  int               del_pct;
  int               clr_pct;
  logic [VAL_W-1:0] pool [POOL_N];

  initial clk = 1'b0;
  always #2 clk = ~clk;

  integer_set_engine_core uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .in_req   (in_req),
    .busy     (busy),
    .out_valid(out_valid),
    .out_rsp  (out_rsp)
  );

  integer_set_checker chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_rsp   (out_rsp),
    .fail_count(fail_count),
    .pending   (pending)
  );

  // start is only lowered when a gap is drawn, so back-to-back items keep it high
  task automatic send_item(input logic [1:0] op, input logic [VAL_W-1:0] val);
    int gap;
    gap = (gap_max == 0) ? 0 : $urandom_range(gap_max, 0);
    repeat (gap) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start  <= 1'b1;
    in_req <= req_t'{opcode: op, value: val};
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
  endtask

  function automatic logic [VAL_W-1:0] pick_value();
    int r;
    r = $urandom_range(99);
    if (r < 70) return pool[$urandom_range(POOL_N - 1)];
    if (r < 85) return $urandom;
    case ($urandom_range(3))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0000_0000;
      default: return 32'hffff_ffff;
    endcase
  endfunction

  function automatic logic [1:0] pick_op();
    int r;
    r = $urandom_range(99);
    if (r < clr_pct) return OP_CLEAR;
    if (r < clr_pct + ins_pct) return OP_INSERT;
    if (r < clr_pct + ins_pct + del_pct) return OP_DELETE;
    return OP_SEARCH;
  endfunction

  initial begin
    rst_n   = 1'b0;
    start   = 1'b0;
    in_req  = '0;
    gap_max = 10;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // directed: extremes, duplicates, misses, full table, slot reuse, clear
    send_item(OP_SEARCH, 32'h0000_0005);
    send_item(OP_INSERT, 32'h8000_0000);
    send_item(OP_INSERT, 32'h7fff_ffff);
    send_item(OP_INSERT, 32'h0000_0000);
    send_item(OP_INSERT, 32'hffff_ffff);
    send_item(OP_INSERT, 32'h0000_0001);
    send_item(OP_INSERT, 32'h7fff_ffff);
    send_item(OP_SEARCH, 32'h8000_0000);
    send_item(OP_SEARCH, 32'hffff_ffff);
    send_item(OP_DELETE, 32'h0000_0000);
    send_item(OP_DELETE, 32'h0000_0000);
    for (int k = 0; k < CAPACITY - 4; k++) send_item(OP_INSERT, 32'(100 + k));
    send_item(OP_INSERT, 32'h0000_1234);
    send_item(OP_INSERT, 32'h7fff_ffff);
    send_item(OP_SEARCH, 32'(100 + CAPACITY - 5));
    send_item(OP_DELETE, 32'h8000_0000);
    send_item(OP_INSERT, 32'h8000_0000);
    send_item(OP_CLEAR, $urandom);
    send_item(OP_SEARCH, 32'h7fff_ffff);

    for (int blk = 0; blk < 17; blk++) begin
      foreach (pool[i]) pool[i] = $urandom;
      pool[$urandom_range(POOL_N - 1)] = 32'h8000_0000;
      pool[$urandom_range(POOL_N - 1)] = 32'h7fff_ffff;
      ins_pct = $urandom_range(60, 25);
      del_pct = $urandom_range(35, 10);
      clr_pct = $urandom_range(4, 0);
      gap_max = ($urandom_range(3) == 0) ? 0 : 10;
      for (int n = 0; n < 100; n++) send_item(pick_op(), pick_value());
    end

    @(negedge clk);
    start <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (CAPACITY + 8) @(negedge clk);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
